// ===== design/eabv_pkg.sv =====
`default_nettype none

package eabv_pkg;

    localparam int TABLE_BITS    = 10;
    localparam int FRACTION_BITS = 14;
    localparam int ANGLE_W       = 16;
    localparam int FIELD_W       = 16;

    // signed sine/cosine and product width: holds +-2^FRACTION_BITS
    localparam int SW      = FRACTION_BITS + 2;
    localparam int SUM_W   = SW + 1;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int ROM_W   = (QUARTER + 1) * SW;

    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;

    typedef logic signed [SW-1:0]      sval_t;
    typedef logic signed [SUM_W-1:0]   ssum_t;
    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [TABLE_BITS-1:0]     tidx_t;
    typedef logic [TABLE_BITS-2:0]     taddr_t;

    localparam ssum_t UNIT_S = ssum_t'(1 << FRACTION_BITS);

    typedef struct packed {
        logic [ANGLE_W-1:0] pitch_angle;
        logic [ANGLE_W-1:0] yaw_angle;
        logic [ANGLE_W-1:0] roll_angle;
    } angles_t;

    typedef struct packed {
        field_t forward_x;
        field_t forward_y;
        field_t forward_z;
        field_t right_x;
        field_t right_y;
        field_t right_z;
        field_t up_x;
        field_t up_y;
        field_t up_z;
    } basis_t;

    typedef struct packed {
        sval_t sp;
        sval_t cp;
        sval_t sy;
        sval_t cy;
        sval_t sr;
        sval_t cr;
    } trig_t;

    // first product level; a and b feed the second level with sy/cy
    typedef struct packed {
        sval_t fx;
        sval_t fy;
        sval_t fz;
        sval_t a;
        sval_t rxb;
        sval_t ryb;
        sval_t rz;
        sval_t b;
        sval_t uxb;
        sval_t uyb;
        sval_t uz;
        sval_t sy;
        sval_t cy;
    } prod_t;

    typedef struct packed {
        sval_t fx;
        sval_t fy;
        sval_t fz;
        sval_t rxa;
        sval_t rxb;
        sval_t rya;
        sval_t ryb;
        sval_t rz;
        sval_t uxa;
        sval_t uxb;
        sval_t uya;
        sval_t uyb;
        sval_t uz;
    } chain_t;

    // (a * b) >> 61, elaboration only
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] s, input logic [63:0] t);
        return (s >= t) ? s - t : 64'd0;
    endfunction

    // Quarter-wave sine, Taylor series in Q61, rounded to FRACTION_BITS
    function automatic logic [ROM_W-1:0] build_sine_rom();
        logic [ROM_W-1:0] rom;
        logic [63:0]      x;
        logic [63:0]      x2;
        logic [63:0]      term;
        logic [63:0]      sum;
        rom = '0;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (HALF_PI_Q61 / 64'(QUARTER)) * 64'(k)
                + ((HALF_PI_Q61 % 64'(QUARTER)) * 64'(k)) / 64'(QUARTER);
            x2   = mul_q61(x, x);
            term = x;
            sum  = x;
            term = mul_q61(term, x2) / 64'd6;   sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd20;  sum = sum + term;
            term = mul_q61(term, x2) / 64'd42;  sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd72;  sum = sum + term;
            term = mul_q61(term, x2) / 64'd110; sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd156; sum = sum + term;
            term = mul_q61(term, x2) / 64'd210; sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd272; sum = sum + term;
            term = mul_q61(term, x2) / 64'd342; sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd420; sum = sum + term;
            term = mul_q61(term, x2) / 64'd506; sum = sub_floor(sum, term);
            term = mul_q61(term, x2) / 64'd600; sum = sum + term;
            term = mul_q61(term, x2) / 64'd702; sum = sub_floor(sum, term);
            sum = (sum + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS);
            if (sum > (64'd1 << FRACTION_BITS))
            begin
                sum = 64'd1 << FRACTION_BITS;
            end
            rom[k*SW +: SW] = sum[SW-1:0];
        end
        return rom;
    endfunction

    localparam logic [ROM_W-1:0] SINE_ROM = build_sine_rom();

    function automatic sval_t table_sine(input tidx_t idx);
        logic [1:0]            quad;
        logic [TABLE_BITS-3:0] pos;
        taddr_t                addr;
        sval_t                 v;
        quad = idx[TABLE_BITS-1 -: 2];
        pos  = idx[TABLE_BITS-3:0];
        addr = quad[0] ? taddr_t'(QUARTER) - taddr_t'(pos) : taddr_t'(pos);
        v    = sval_t'(SINE_ROM[addr*SW +: SW]);
        return quad[1] ? -v : v;
    endfunction

    // floor((a * b) / 2^FRACTION_BITS)
    function automatic sval_t fx_mul(input sval_t a, input sval_t b);
        logic signed [2*SW-1:0] p;
        p = a * b;
        return sval_t'(p >>> FRACTION_BITS);
    endfunction

    function automatic field_t clamp_field(input ssum_t v);
        ssum_t c;
        if (v > UNIT_S)
        begin
            c = UNIT_S;
        end
        else if (v < -UNIT_S)
        begin
            c = -UNIT_S;
        end
        else
        begin
            c = v;
        end
        return field_t'(c);
    endfunction

endpackage

`default_nettype wire

// ===== design/euler_angles_to_basis_vectors.sv =====
// Channel   Handshake                   Payload
// angles    angles_valid / angles_stall  pitch, yaw, roll binary angles (eabv_pkg::angles_t)
// basis     basis_valid / basis_stall    forward, right, up vectors in Q1.14 (eabv_pkg::basis_t)
//
// One transfer per cycle on each side while basis is not stalled; an input transfer passes
// through the registered stages to the output: table lookup, first products, chained products, sum and clamp.
// Reset clears the four stage valid bits; the sine table is constant logic.
// A stall on basis holds the output register and backs up only as far as needed:
// each stage keeps loading while it or the stage after it has room.
`default_nettype none

module euler_angles_to_basis_vectors (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             angles_valid,
    output logic                  angles_stall,
    input  wire eabv_pkg::angles_t angles,
    output logic                  basis_valid,
    input  wire logic             basis_stall,
    output eabv_pkg::basis_t      basis
);

    logic              trig_valid;
    logic              trig_stall;
    eabv_pkg::trig_t   trig;
    logic              prod_valid;
    logic              prod_stall;
    eabv_pkg::prod_t   prod;
    logic              chain_valid;
    logic              chain_stall;
    eabv_pkg::chain_t  chain;

    eabv_trig u_trig (
        .clk          (clk),
        .rst_n        (rst_n),
        .angles_valid (angles_valid),
        .angles_stall (angles_stall),
        .angles       (angles),
        .trig_valid   (trig_valid),
        .trig_stall   (trig_stall),
        .trig         (trig)
    );

    eabv_prod u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_valid (trig_valid),
        .trig_stall (trig_stall),
        .trig       (trig),
        .prod_valid (prod_valid),
        .prod_stall (prod_stall),
        .prod       (prod)
    );

    eabv_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .prod_valid  (prod_valid),
        .prod_stall  (prod_stall),
        .prod        (prod),
        .chain_valid (chain_valid),
        .chain_stall (chain_stall),
        .chain       (chain)
    );

    eabv_sum u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .chain_valid (chain_valid),
        .chain_stall (chain_stall),
        .chain       (chain),
        .basis_valid (basis_valid),
        .basis_stall (basis_stall),
        .basis       (basis)
    );

`ifndef SYNTHESIS
    // input backs up only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        angles_stall |-> (basis_valid && basis_stall && chain_valid && prod_valid
                          && trig_valid))
        else $error("input stalled while the pipeline has room");

    // with no output stall an accepted transfer reaches the output through the trig, product, chain and sum registers
    assert property (@(posedge clk) disable iff (!rst_n)
        (angles_valid && !angles_stall) ##1 !basis_stall ##1 !basis_stall ##1 !basis_stall
        |=> basis_valid)
        else $error("accepted transfer did not reach the output");

    // clamping keeps the summed components on the unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        basis_valid |-> (basis.right_x <= 16'sd16384 && basis.right_x >= -16'sd16384
                         && basis.up_y <= 16'sd16384 && basis.up_y >= -16'sd16384))
        else $error("summed component outside unit range");
`endif

endmodule

`default_nettype wire

// ===== design/eabv_trig.sv =====
`default_nettype none

module eabv_trig (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             angles_valid,
    output logic                  angles_stall,
    input  wire eabv_pkg::angles_t angles,
    output logic                  trig_valid,
    input  wire logic             trig_stall,
    output eabv_pkg::trig_t       trig
);

    logic              valid_reg;
    logic              advance;
    eabv_pkg::trig_t   trig_reg;
    eabv_pkg::trig_t   trig_next;
    eabv_pkg::tidx_t   ip;
    eabv_pkg::tidx_t   iy;
    eabv_pkg::tidx_t   ir;

    assign advance      = !valid_reg || !trig_stall;
    assign angles_stall = !advance;

    // angle bits below the table index are dropped
    always_comb
    begin
        ip = angles.pitch_angle[eabv_pkg::ANGLE_W-1 -: eabv_pkg::TABLE_BITS];
        iy = angles.yaw_angle[eabv_pkg::ANGLE_W-1 -: eabv_pkg::TABLE_BITS];
        ir = angles.roll_angle[eabv_pkg::ANGLE_W-1 -: eabv_pkg::TABLE_BITS];
        trig_next.sp = eabv_pkg::table_sine(ip);
        trig_next.cp = eabv_pkg::table_sine(ip + eabv_pkg::tidx_t'(eabv_pkg::QUARTER));
        trig_next.sy = eabv_pkg::table_sine(iy);
        trig_next.cy = eabv_pkg::table_sine(iy + eabv_pkg::tidx_t'(eabv_pkg::QUARTER));
        trig_next.sr = eabv_pkg::table_sine(ir);
        trig_next.cr = eabv_pkg::table_sine(ir + eabv_pkg::tidx_t'(eabv_pkg::QUARTER));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= angles_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && angles_valid)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig_valid = valid_reg;
    assign trig       = trig_reg;

endmodule

`default_nettype wire

// ===== design/eabv_prod.sv =====
`default_nettype none

module eabv_prod (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             trig_valid,
    output logic                  trig_stall,
    input  wire eabv_pkg::trig_t  trig,
    output logic                  prod_valid,
    input  wire logic             prod_stall,
    output eabv_pkg::prod_t       prod
);

    logic              valid_reg;
    logic              advance;
    eabv_pkg::prod_t   prod_reg;
    eabv_pkg::prod_t   prod_next;

    assign advance    = !valid_reg || !prod_stall;
    assign trig_stall = !advance;

    always_comb
    begin
        prod_next.fx  = eabv_pkg::fx_mul(trig.cp, trig.cy);
        prod_next.fy  = eabv_pkg::fx_mul(trig.cp, trig.sy);
        prod_next.fz  = -trig.sp;
        prod_next.a   = eabv_pkg::fx_mul(-trig.sr, trig.sp);
        prod_next.rxb = eabv_pkg::fx_mul(-trig.cr, -trig.sy);
        prod_next.ryb = eabv_pkg::fx_mul(-trig.cr, trig.cy);
        prod_next.rz  = eabv_pkg::fx_mul(-trig.sr, trig.cp);
        prod_next.b   = eabv_pkg::fx_mul(trig.cr, trig.sp);
        prod_next.uxb = eabv_pkg::fx_mul(-trig.sr, -trig.sy);
        prod_next.uyb = eabv_pkg::fx_mul(-trig.sr, trig.cy);
        prod_next.uz  = eabv_pkg::fx_mul(trig.cr, trig.cp);
        prod_next.sy  = trig.sy;
        prod_next.cy  = trig.cy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= trig_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && trig_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

// ===== design/eabv_chain.sv =====
`default_nettype none

module eabv_chain (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             prod_valid,
    output logic                  prod_stall,
    input  wire eabv_pkg::prod_t  prod,
    output logic                  chain_valid,
    input  wire logic             chain_stall,
    output eabv_pkg::chain_t      chain
);

    logic              valid_reg;
    logic              advance;
    eabv_pkg::chain_t  chain_reg;
    eabv_pkg::chain_t  chain_next;

    assign advance    = !valid_reg || !chain_stall;
    assign prod_stall = !advance;

    // second level of the chained products: (-sr*sp) and (cr*sp) times cy and sy
    always_comb
    begin
        chain_next.fx  = prod.fx;
        chain_next.fy  = prod.fy;
        chain_next.fz  = prod.fz;
        chain_next.rxa = eabv_pkg::fx_mul(prod.a, prod.cy);
        chain_next.rxb = prod.rxb;
        chain_next.rya = eabv_pkg::fx_mul(prod.a, prod.sy);
        chain_next.ryb = prod.ryb;
        chain_next.rz  = prod.rz;
        chain_next.uxa = eabv_pkg::fx_mul(prod.b, prod.cy);
        chain_next.uxb = prod.uxb;
        chain_next.uya = eabv_pkg::fx_mul(prod.b, prod.sy);
        chain_next.uyb = prod.uyb;
        chain_next.uz  = prod.uz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && prod_valid)
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_valid = valid_reg;
    assign chain       = chain_reg;

endmodule

`default_nettype wire

// ===== design/eabv_sum.sv =====
`default_nettype none

module eabv_sum (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             chain_valid,
    output logic                  chain_stall,
    input  wire eabv_pkg::chain_t chain,
    output logic                  basis_valid,
    input  wire logic             basis_stall,
    output eabv_pkg::basis_t      basis
);

    logic              valid_reg;
    logic              advance;
    eabv_pkg::basis_t  basis_reg;
    eabv_pkg::basis_t  basis_next;

    assign advance     = !valid_reg || !basis_stall;
    assign chain_stall = !advance;

    always_comb
    begin
        basis_next.forward_x = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.fx));
        basis_next.forward_y = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.fy));
        basis_next.forward_z = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.fz));
        basis_next.right_x   = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.rxa)
                                                     + eabv_pkg::ssum_t'(chain.rxb));
        basis_next.right_y   = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.rya)
                                                     + eabv_pkg::ssum_t'(chain.ryb));
        basis_next.right_z   = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.rz));
        basis_next.up_x      = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.uxa)
                                                     + eabv_pkg::ssum_t'(chain.uxb));
        basis_next.up_y      = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.uya)
                                                     + eabv_pkg::ssum_t'(chain.uyb));
        basis_next.up_z      = eabv_pkg::clamp_field(eabv_pkg::ssum_t'(chain.uz));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= chain_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && chain_valid)
        begin
            basis_reg <= basis_next;
        end
    end

    assign basis_valid = valid_reg;
    assign basis       = basis_reg;

endmodule

`default_nettype wire
